/* sv/rle1_pkg.sv */
package rle1_pkg;

  localparam logic [7:0] REP_MASK   = 8'h7F;
  localparam logic [7:0] REP_BIAS   = 8'd2;
  localparam logic [7:0] LIT_BIAS   = 8'd1;
  localparam int unsigned REP_FLAG_BIT = 7;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned LIMIT_W      = 24;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd65536;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LITERAL,
    PH_REPEAT
  } rle1_phase_e;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } rle1_bstate_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } rle1_in_t;

  typedef struct packed {
    logic [63:0] data_bytes;
    logic [3:0]  byte_count;
    logic        decode_done;
    logic        overflow_error;
    logic        last_of_item;
  } rle1_out_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] fill_byte;
    logic [7:0] total;
    logic       check;
    logic       stream_end;
  } rle1_cmd_t;

endpackage

/* sv/rle1_front.sv */
module rle1_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rle1_pkg::rle1_in_t in_item_i,
  input  logic               cmd_ready_i,
  output logic               cmd_valid_o,
  output rle1_pkg::rle1_cmd_t cmd_o
);

  rle1_pkg::rle1_phase_e phase_q, phase_d;
  logic [7:0]            rem_q, rem_d;
  logic                  accept;

  assign in_ready_o  = cmd_ready_i;
  assign accept      = in_valid_i && cmd_ready_i;
  assign cmd_valid_o = in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rle1_pkg::PH_HEADER;
      rem_q   <= 8'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
    end
  end

  always_comb begin
    phase_d           = phase_q;
    rem_d             = rem_q;
    cmd_o.first_byte  = in_item_i.in_byte;
    cmd_o.fill_byte   = 8'h00;
    cmd_o.total       = 8'd0;
    cmd_o.check       = 1'b0;
    cmd_o.stream_end  = in_item_i.stream_end;
    case (phase_q)
      rle1_pkg::PH_LITERAL: begin
        cmd_o.total = in_item_i.stream_end ? rem_q : 8'd1;
        if (in_item_i.stream_end || rem_q == 8'd1) begin
          cmd_o.check = 1'b1;
          phase_d     = rle1_pkg::PH_HEADER;
          rem_d       = 8'd0;
        end else begin
          rem_d = rem_q - 8'd1;
        end
      end
      rle1_pkg::PH_REPEAT: begin
        cmd_o.total     = rem_q;
        cmd_o.fill_byte = in_item_i.in_byte;
        cmd_o.check     = 1'b1;
        phase_d         = rle1_pkg::PH_HEADER;
        rem_d           = 8'd0;
      end
      default: begin
        if (!in_item_i.stream_end) begin
          if (in_item_i.in_byte[rle1_pkg::REP_FLAG_BIT]) begin
            rem_d   = (in_item_i.in_byte & rle1_pkg::REP_MASK) + rle1_pkg::REP_BIAS;
            phase_d = rle1_pkg::PH_REPEAT;
          end else begin
            rem_d   = in_item_i.in_byte + rle1_pkg::LIT_BIAS;
            phase_d = rle1_pkg::PH_LITERAL;
          end
        end
      end
    endcase
    if (in_item_i.stream_end) begin
      phase_d = rle1_pkg::PH_HEADER;
      rem_d   = 8'd0;
    end
  end

endmodule

/* sv/rle1_queue.sv */
module rle1_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  rle1_pkg::rle1_cmd_t push_cmd_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output rle1_pkg::rle1_cmd_t pop_cmd_o
);

  localparam int unsigned AW = $clog2(rle1_pkg::QUEUE_DEPTH);

  rle1_pkg::rle1_cmd_t mem_q [rle1_pkg::QUEUE_DEPTH];
  logic [AW-1:0]       wr_q, rd_q;
  logic [AW:0]         cnt_q;
  logic                push, pop;

  assign push_ready_o = cnt_q != (AW+1)'(rle1_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == AW'(rle1_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == AW'(rle1_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* sv/rle1_back.sv */
module rle1_back #(
  parameter int unsigned PACK_BYTES = 8,
  parameter int unsigned LIMIT_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rle1_pkg::LIMIT_W-1:0]      cfg_data_i,
  input  logic                              cmd_valid_i,
  output logic                              cmd_ready_o,
  input  rle1_pkg::rle1_cmd_t               cmd_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rle1_pkg::rle1_out_t               out_item_o
);

  localparam int unsigned BW = LIMIT_BITS + 1;
  localparam logic [7:0]  PACK8   = 8'(PACK_BYTES);
  localparam logic [3:0]  PACK4   = 4'(PACK_BYTES);

  rle1_pkg::rle1_bstate_e st_q, st_d;
  logic [LIMIT_BITS-1:0]  lim_q;
  logic [BW-1:0]          bw_q, bw_d;
  logic                   halted_q, halted_d, failed_q, failed_d;
  logic [7:0]             left_q, left_d;
  logic                   first_q, first_d;
  logic [7:0]             first_byte_q, first_byte_d, fill_q, fill_d;
  logic                   done_q, done_d, ovf_q, ovf_d;
  logic                   out_valid_q, out_valid_d;
  rle1_pkg::rle1_out_t    out_q, out_d, beat;
  logic [BW-1:0]          lim_ext, new_bw, avail;
  logic [7:0]             run_cnt;
  logic [3:0]             cnt;
  logic                   slot_free;

  assign cmd_ready_o = st_q == rle1_pkg::BK_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign lim_ext     = BW'(lim_q);
  assign new_bw      = bw_q + BW'(cmd_i.total);
  assign avail       = (bw_q < lim_ext) ? lim_ext - bw_q : '0;
  assign run_cnt     = (avail < BW'(cmd_i.total)) ? avail[7:0] : cmd_i.total;
  assign cnt         = (left_q < PACK8) ? left_q[3:0] : PACK4;

  always_comb begin
    beat                = '0;
    beat.byte_count     = cnt;
    beat.decode_done    = done_q;
    beat.overflow_error = ovf_q;
    beat.last_of_item   = left_q <= PACK8;
    for (int j = 0; j < PACK_BYTES; j++) begin
      if (4'(j) < cnt) begin
        beat.data_bytes[8*j +: 8] = (j == 0 && first_q) ? first_byte_q : fill_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LIMIT_BITS'(rle1_pkg::LIMIT_RESET);
    end else if (cfg_we_i) begin
      lim_q <= LIMIT_BITS'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= rle1_pkg::BK_IDLE;
      bw_q        <= '0;
      halted_q    <= 1'b0;
      failed_q    <= 1'b0;
      left_q      <= 8'd0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      bw_q        <= bw_d;
      halted_q    <= halted_d;
      failed_q    <= failed_d;
      left_q      <= left_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_byte_q <= first_byte_d;
    fill_q       <= fill_d;
    done_q       <= done_d;
    ovf_q        <= ovf_d;
    out_q        <= out_d;
  end

  always_comb begin
    st_d         = st_q;
    bw_d         = bw_q;
    halted_d     = halted_q;
    failed_d     = failed_q;
    left_d       = left_q;
    first_d      = first_q;
    first_byte_d = first_byte_q;
    fill_d       = fill_q;
    done_d       = done_q;
    ovf_d        = ovf_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    case (st_q)
      rle1_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          first_byte_d = cmd_i.first_byte;
          fill_d       = cmd_i.fill_byte;
          first_d      = 1'b1;
          st_d         = rle1_pkg::BK_EMIT;
          if (halted_q) begin
            left_d = 8'd0;
            done_d = 1'b1;
            ovf_d  = failed_q;
          end else begin
            left_d = run_cnt;
            bw_d   = new_bw;
            if (cmd_i.check) begin
              halted_d = new_bw >= lim_ext;
              failed_d = failed_q || (new_bw > lim_ext);
            end
            done_d = halted_d || cmd_i.stream_end;
            ovf_d  = failed_d;
          end
          if (cmd_i.stream_end) begin
            bw_d     = '0;
            halted_d = 1'b0;
            failed_d = 1'b0;
          end
        end
      end
      rle1_pkg::BK_EMIT: begin
        if (slot_free) begin
          out_d       = beat;
          out_valid_d = 1'b1;
          left_d      = left_q - {4'd0, cnt};
          first_d     = 1'b0;
          if (left_q <= PACK8) begin
            st_d = rle1_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        st_d = rle1_pkg::BK_IDLE;
      end
    endcase
  end

endmodule

/* sv/rle_type1_decoder.sv */
// Channel  Dir  Handshake               Payload
// in       in   in_valid_i/in_ready_o   in_item_i  (rle1_pkg::rle1_in_t)
// out      out  out_valid_o/out_ready_i out_item_o (rle1_pkg::rle1_out_t)
// cfg      in   cfg_we_i                cfg_data_i (output_limit)
//
// The front takes one item per cycle while its two-entry queue has room.
// The back takes an item only while idle, then emits that item's result beats,
// holding each one while the output is stalled, and returns to idle after the last.
// Reset clears all control state at once; no clearing pass.
// Output stalls hold the back, which fills the queue and then holds in_ready_o low.
module rle_type1_decoder #(
  parameter int unsigned PACK_BYTES = 8,
  parameter int unsigned LIMIT_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rle1_pkg::rle1_in_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rle1_pkg::rle1_out_t          out_item_o,
  input  logic                         cfg_we_i,
  input  logic [rle1_pkg::LIMIT_W-1:0] cfg_data_i
);

  logic                f_valid, f_ready, b_valid, b_ready;
  rle1_pkg::rle1_cmd_t f_cmd, b_cmd;

  rle1_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_ready_i (f_ready),
    .cmd_valid_o (f_valid),
    .cmd_o       (f_cmd)
  );

  rle1_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_cmd_o    (b_cmd)
  );

  rle1_back #(
    .PACK_BYTES (PACK_BYTES),
    .LIMIT_BITS (LIMIT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* sv/rle1_checker.sv */
module rle1_checker #(
  parameter int unsigned PACK_BYTES = 8
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rle1_pkg::rle1_out_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.byte_count <= 4'(PACK_BYTES))
    else $error("byte count above pack size");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.byte_count == 4'd0 |-> out_item_o.last_of_item)
    else $error("empty result not last of item");

  a_full_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last_of_item |-> out_item_o.byte_count == 4'(PACK_BYTES))
    else $error("inner result not full");

endmodule

bind rle_type1_decoder rle1_checker #(
  .PACK_BYTES (PACK_BYTES)
) u_rle1_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PACK = 8;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned RANDOM_ITEMS = 250;

  class packbits_tracker;
    rle1_pkg::rle1_out_t beats_due[$];
    logic [7:0] decoded[$];
    logic [rle1_pkg::LIMIT_W-1:0] limit;
    rle1_pkg::rle1_phase_e ph;
    logic [7:0] lit_left;
    logic [7:0] rep_len;
    int unsigned produced;
    bit stopped;
    bit overran;
    int unsigned live_items;
    int unsigned mismatches;

    function new();
      limit = rle1_pkg::LIMIT_RESET;
      live_items = 0;
      mismatches = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      ph = rle1_pkg::PH_HEADER;
      lit_left = '0;
      rep_len = '0;
      produced = 0;
      stopped = 1'b0;
      overran = 1'b0;
    endfunction

    // drop bytes past the limit but keep counting them
    function void put(logic [7:0] b);
      if (produced < limit) decoded.push_back(b);
      produced++;
    endfunction

    function void close_run();
      if (produced == limit) begin
        stopped = 1'b1;
      end else if (produced > limit) begin
        stopped = 1'b1;
        overran = 1'b1;
      end
    endfunction

    function void take_byte(rle1_pkg::rle1_in_t it);
      rle1_pkg::rle1_out_t beat;
      int unsigned nres;
      decoded.delete();
      live_items++;
      if (!stopped) begin
        case (ph)
          rle1_pkg::PH_LITERAL: begin
            put(it.in_byte);
            if (lit_left != 0) lit_left--;
            if (it.stream_end) begin
              while (lit_left != 0) begin
                put(8'h00);
                lit_left--;
              end
            end
            if (lit_left == 0) begin
              ph = rle1_pkg::PH_HEADER;
              close_run();
            end
          end
          rle1_pkg::PH_REPEAT: begin
            repeat (rep_len) put(it.in_byte);
            rep_len = '0;
            ph = rle1_pkg::PH_HEADER;
            close_run();
          end
          default: begin
            if (it.stream_end) begin
              ph = rle1_pkg::PH_HEADER;
            end else if (it.in_byte[rle1_pkg::REP_FLAG_BIT]) begin
              rep_len = (it.in_byte & rle1_pkg::REP_MASK) + rle1_pkg::REP_BIAS;
              ph = rle1_pkg::PH_REPEAT;
            end else begin
              lit_left = it.in_byte + rle1_pkg::LIT_BIAS;
              ph = rle1_pkg::PH_LITERAL;
            end
          end
        endcase
      end
      nres = (decoded.size() == 0) ? 1 : (decoded.size() + PACK - 1) / PACK;
      for (int k = 0; k < nres; k++) begin
        beat = '0;
        for (int j = 0; j < PACK; j++) begin
          if (k * PACK + j < decoded.size()) begin
            beat.data_bytes[8*j +: 8] = decoded[k * PACK + j];
            beat.byte_count++;
          end
        end
        beat.decode_done = stopped || it.stream_end;
        beat.overflow_error = overran;
        beat.last_of_item = (k == nres - 1);
        beats_due.push_back(beat);
      end
      if (it.stream_end) clear_stream();
    endfunction

    function void match_beat(rle1_pkg::rle1_out_t got);
      rle1_pkg::rle1_out_t want;
      if (beats_due.size() == 0) begin
        $error("unexpected result %h", got);
        mismatches++;
        return;
      end
      want = beats_due.pop_front();
      if (got.data_bytes !== want.data_bytes) begin
        $error("data_bytes: expected %h, got %h", want.data_bytes, got.data_bytes);
        mismatches++;
      end
      if (got.byte_count !== want.byte_count) begin
        $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
        mismatches++;
      end
      if (got.decode_done !== want.decode_done) begin
        $error("decode_done: expected %b, got %b", want.decode_done, got.decode_done);
        mismatches++;
      end
      if (got.overflow_error !== want.overflow_error) begin
        $error("overflow_error: expected %b, got %b", want.overflow_error,
               got.overflow_error);
        mismatches++;
      end
      if (got.last_of_item !== want.last_of_item) begin
        $error("last_of_item: expected %b, got %b", want.last_of_item, got.last_of_item);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  rle1_pkg::rle1_in_t in_item_i;
  logic out_valid_o;
  logic out_ready_i;
  rle1_pkg::rle1_out_t out_item_o;
  logic cfg_we_i;
  logic [rle1_pkg::LIMIT_W-1:0] cfg_data_i;

  packbits_tracker ledger = new();
  rle1_pkg::rle1_in_t feed[$];
  bit gaps_on = 1'b1;
  bit rx_stall = 1'b1;
  int unsigned hold_left = 0;

  rle_type1_decoder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i && in_ready_o) ledger.take_byte(in_item_i);
      if (out_valid_o && out_ready_i) ledger.match_beat(out_item_o);
    end
  end

  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (rx_stall && $urandom_range(99) < 35) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

  task automatic push(input int b, input bit e);
    rle1_pkg::rle1_in_t it;
    it.in_byte = b[7:0];
    it.stream_end = e;
    feed.push_back(it);
  endtask

  task automatic send_item(input rle1_pkg::rle1_in_t it);
    if (gaps_on && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 45);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  task automatic send_feed();
    foreach (feed[i]) send_item(feed[i]);
    feed.delete();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (ledger.beats_due.size() != 0);
  endtask

  task automatic write_limit(input int unsigned value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value[rle1_pkg::LIMIT_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.limit = value[rle1_pkg::LIMIT_W-1:0];
  endtask

  task automatic build_stream();
    int npk;
    int n;
    int k;
    feed.delete();
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 10);
      repeat (n) push($urandom_range(255), 1'b0);
      feed[feed.size() - 1].stream_end = 1'b1;
      return;
    end
    npk = $urandom_range(1, 6);
    repeat (npk) begin
      if ($urandom_range(1) == 1) begin
        n = ($urandom_range(11) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 10);
        push(n - 1, 1'b0);
        repeat (n) push($urandom_range(255), 1'b0);
      end else begin
        n = ($urandom_range(9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 14);
        push(8'h80 | n, 1'b0);
        push($urandom_range(255), 1'b0);
      end
    end
    case ($urandom_range(9))
      0: begin
        n = $urandom_range(2, 60);
        k = $urandom_range(1, n - 1);
        push(n - 1, 1'b0);
        repeat (k - 1) push($urandom_range(255), 1'b0);
        push($urandom_range(255), 1'b1);
      end
      1: push($urandom_range(255), 1'b1);
      2: begin
        push(8'h80 | $urandom_range(127), 1'b0);
        push($urandom_range(255), 1'b1);
      end
      default: feed[feed.size() - 1].stream_end = 1'b1;
    endcase
  endtask

  initial begin
    int unsigned base;
    int stream_no;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_data_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push(8'h00, 1'b0); push(8'hFF, 1'b0);
    push(8'hFF, 1'b0); push(8'hA5, 1'b0);
    push(8'h80, 1'b0); push(8'h00, 1'b0);
    push(8'h7F, 1'b0); push(8'h5A, 1'b0); push(8'hC3, 1'b1);
    push(8'h81, 1'b1);
    send_feed();

    write_limit(24'd3);
    push(8'h01, 1'b0); push(8'h11, 1'b0); push(8'h22, 1'b0);
    push(8'h80, 1'b0); push(8'h33, 1'b0);
    push(8'h44, 1'b0); push(8'h55, 1'b1);
    send_feed();

    write_limit(24'd2);
    push(8'h80, 1'b0); push(8'hEE, 1'b0); push(8'h01, 1'b1);
    send_feed();

    write_limit(24'd0);
    push(8'h00, 1'b0); push(8'h77, 1'b1);
    send_feed();

    write_limit(24'hFFFFFF);
    push(8'hFE, 1'b0); push(8'h0F, 1'b1);
    send_feed();

    base = ledger.live_items;
    stream_no = 0;
    while (ledger.live_items - base < RANDOM_ITEMS) begin
      if (stream_no % 4 == 3) begin
        case ($urandom_range(4))
          0: write_limit(24'd0);
          1: write_limit(24'hFFFFFF);
          2: write_limit($urandom_range(1, 40));
          3: write_limit($urandom_range(41, 400));
          default: write_limit(rle1_pkg::LIMIT_RESET);
        endcase
      end
      if (stream_no == 2) hold_left = 400;
      if (stream_no == 5) wait_drained();
      gaps_on = !(stream_no >= 6 && stream_no <= 8);
      rx_stall = gaps_on;
      build_stream();
      send_feed();
      stream_no++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (ledger.beats_due.size() != 0)
      $error("%0d expected results never arrived", ledger.beats_due.size());
    if (ledger.mismatches == 0 && ledger.beats_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
